### hdl/sarl_pkg.sv
// package: shared constants, types and helpers for the sorted address range lookup
`default_nettype none
package sarl_pkg;

  localparam int unsigned MAX_RANGES = 64;
  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned FIELD_W    = 32;
  localparam int unsigned ID_W       = 16;
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned GROUP_SIZE = 8;
  localparam int unsigned NUM_GROUPS = (MAX_RANGES + GROUP_SIZE - 1) / GROUP_SIZE;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 2'd0,
    KIND_LOOKUP = 2'd1,
    KIND_CLEAR  = 2'd2,
    KIND_NOP    = 2'd3
  } kind_e;

  // one stored range
  typedef struct packed {
    logic                valid;
    logic [ADDR_W-1:0]   start;
    logic [ADDR_W:0]     stop;
    logic [ID_W-1:0]     id;
  } entry_t;

  // command broadcast to every cell
  typedef struct packed {
    logic                advance;
    logic                insert;
    logic                lookup;
    logic                clear;
    logic [ADDR_W-1:0]   offset;
    logic [ADDR_W-1:0]   length;
    logic [ADDR_W:0]     stop;
    logic [ID_W-1:0]     id;
  } cell_cmd_t;

  // per-cell lookup result, all zero unless this cell matched
  typedef struct packed {
    logic              hit;
    logic [ID_W-1:0]   id;
    logic              fits;
  } res_t;

  localparam int unsigned RES_W = $bits(res_t);

  // keep the low field bits that fit the address width
  function automatic logic [ADDR_W-1:0] to_addr(input logic [FIELD_W-1:0] v);
    logic [ADDR_W-1:0] r;
    r = '0;
    for (int unsigned i = 0; i < ADDR_W; i++) begin
      if (i < FIELD_W) begin
        r[i] = v[i];
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

### hdl/sarl_if.sv
// interfaces: request and response channels of the range lookup
`default_nettype none
interface sarl_req_if;
  logic                                  valid;
  logic                                  ready;
  logic [sarl_pkg::KIND_W-1:0]           kind;
  logic [sarl_pkg::FIELD_W-1:0]          offset;
  logic [sarl_pkg::FIELD_W-1:0]          length;
  logic [sarl_pkg::ID_W-1:0]             segment_id;

  modport source (output valid, kind, offset, length, segment_id, input ready);
  modport sink   (input valid, kind, offset, length, segment_id, output ready);
endinterface

interface sarl_rsp_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  hit;
  logic [sarl_pkg::ID_W-1:0]             found_id;
  logic                                  fits;
  logic                                  status;

  modport source (output valid, hit, found_id, fits, status, input ready);
  modport sink   (input valid, hit, found_id, fits, status, output ready);
endinterface
`default_nettype wire

### hdl/sorted_address_range_lookup.sv
// top level: sorted address range table built as a row of cells with a reduce pipeline
//
//   channel | dir | handshake     | payload
//   --------+-----+---------------+------------------------------------------
//   req     | in  | valid / ready | kind, offset, length, segment_id
//   rsp     | out | valid / ready | hit, found_id, fits, status
//
// one request per cycle while the response is not stalled; each produces one response
// through the cell compare stage, the group or stage and the output register
// an insert shifts the row by one cell in the accept cycle, so a request right behind
// it already sees the new order
// reset empties the table; stored ranges are not cleared, only their valid bits
// a stalled response holds the whole pipeline and deasserts req.ready
`default_nettype none
module sorted_address_range_lookup (
  input  wire          clk_i,
  input  wire          rst_ni,
  sarl_req_if.sink     req,
  sarl_rsp_if.source   rsp
);

  localparam int unsigned N  = sarl_pkg::MAX_RANGES;
  localparam int unsigned G  = sarl_pkg::NUM_GROUPS;
  localparam int unsigned GS = sarl_pkg::GROUP_SIZE;
  localparam int unsigned RW = sarl_pkg::RES_W;

  // pipeline advances whenever the output slot is free or being drained
  logic advance;
  logic req_acc;
  assign advance   = !rsp.valid || rsp.ready;
  assign req.ready = advance;
  assign req_acc   = req.valid && advance;

  // command broadcast to the row
  sarl_pkg::cell_cmd_t        cmd;
  logic [sarl_pkg::ADDR_W-1:0] off_a, len_a;
  logic                       full;

  assign off_a = sarl_pkg::to_addr(req.offset);
  assign len_a = sarl_pkg::to_addr(req.length);

  always_comb begin
    cmd         = '0;
    cmd.advance = advance;
    cmd.offset  = off_a;
    cmd.length  = len_a;
    cmd.stop    = {1'b0, off_a} + {1'b0, len_a};
    cmd.id      = req.segment_id;
    if (req_acc) begin
      unique case (sarl_pkg::kind_e'(req.kind))
        sarl_pkg::KIND_INSERT: cmd.insert = !full;
        sarl_pkg::KIND_LOOKUP: cmd.lookup = 1'b1;
        sarl_pkg::KIND_CLEAR:  cmd.clear  = 1'b1;
        default: ;
      endcase
    end
  end

  // the row: each cell sees its left neighbor's entry and the right neighbor's compare
  sarl_pkg::entry_t entries [N];
  logic [N-1:0]     gr;
  logic [N-1:0]     le;
  logic [RW-1:0]    cres [N];

  for (genvar i = 0; i < N; i++) begin : g_cell
    sarl_pkg::entry_t left;
    logic             left_gr;
    logic             le_right;
    sarl_pkg::res_t   res;

    if (i == 0) begin : g_head
      // the head cell takes the new range whenever it does not keep its own
      assign left    = '{valid: 1'b1, start: '0, stop: '0, id: '0};
      assign left_gr = 1'b1;
    end else begin : g_body
      assign left    = entries[i-1];
      assign left_gr = gr[i-1];
    end

    if (i == N - 1) begin : g_tail
      assign le_right = 1'b0;
    end else begin : g_mid
      assign le_right = le[i+1];
    end

    sarl_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cmd_i      (cmd),
      .left_i     (left),
      .left_gr_i  (left_gr),
      .le_right_i (le_right),
      .entry_o    (entries[i]),
      .gr_o       (gr[i]),
      .le_o       (le[i]),
      .res_o      (res)
    );
    assign cres[i] = res;
  end

  // table full once the last cell holds a range
  assign full = entries[N-1].valid;

  // status travels beside the cell results
  logic s1_status_q, s2_status_q;
  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_status_q <= req_acc && (sarl_pkg::kind_e'(req.kind) == sarl_pkg::KIND_INSERT)
                     && full;
      s2_status_q <= s1_status_q;
    end
  end

  // group stage: or together the one-hot cell results
  logic [RW-1:0] grp_d [G];
  logic [RW-1:0] grp_q [G];

  always_comb begin
    for (int unsigned g = 0; g < G; g++) begin
      grp_d[g] = '0;
      for (int unsigned j = 0; j < GS; j++) begin
        if (g * GS + j < N) begin
          grp_d[g] = grp_d[g] | cres[g * GS + j];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      for (int unsigned g = 0; g < G; g++) begin
        grp_q[g] <= grp_d[g];
      end
    end
  end

  // output stage: final or across groups into the response register
  logic [RW-1:0]  fin_d;
  sarl_pkg::res_t out_q;
  logic           status_q;
  logic           s1_v_q, s2_v_q, out_v_q;

  always_comb begin
    fin_d = '0;
    for (int unsigned g = 0; g < G; g++) begin
      fin_d = fin_d | grp_q[g];
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q    <= sarl_pkg::res_t'(fin_d);
      status_q <= s2_status_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else if (advance) begin
      s1_v_q  <= req_acc;
      s2_v_q  <= s1_v_q;
      out_v_q <= s2_v_q;
    end
  end

  assign rsp.valid    = out_v_q;
  assign rsp.hit      = out_q.hit;
  assign rsp.found_id = out_q.id;
  assign rsp.fits     = out_q.fits;
  assign rsp.status   = status_q;

endmodule
`default_nettype wire

### hdl/sarl_cell.sv
// cell: one slot of the sorted range row with its local lookup compare
`default_nettype none
module sarl_cell (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  sarl_pkg::cell_cmd_t    cmd_i,
  input  sarl_pkg::entry_t       left_i,
  input  wire                    left_gr_i,
  input  wire                    le_right_i,
  output sarl_pkg::entry_t       entry_o,
  output logic                   gr_o,
  output logic                   le_o,
  output sarl_pkg::res_t         res_o
);

  logic                 valid_q, valid_d;
  logic [sarl_pkg::ADDR_W-1:0] start_q, start_d;
  logic [sarl_pkg::ADDR_W:0]   stop_q, stop_d;
  logic [sarl_pkg::ID_W-1:0]   id_q, id_d;
  sarl_pkg::res_t       res_q, res_d;
  logic                 match;
  logic                 in_range;
  logic [sarl_pkg::ADDR_W:0]   room;

  // start below the new one: entry stays put on insert
  assign gr_o = valid_q && (start_q < cmd_i.offset);
  // start at or below the lookup offset
  assign le_o = valid_q && (start_q <= cmd_i.offset);

  assign entry_o = '{valid: valid_q, start: start_q, stop: stop_q, id: id_q};

  always_comb begin
    valid_d = valid_q;
    start_d = start_q;
    stop_d  = stop_q;
    id_d    = id_q;
    if (cmd_i.clear) begin
      valid_d = 1'b0;
    end else if (cmd_i.insert && !gr_o) begin
      valid_d = valid_q | left_i.valid;
      if (left_gr_i) begin
        start_d = cmd_i.offset;
        stop_d  = cmd_i.stop;
        id_d    = cmd_i.id;
      end else begin
        start_d = left_i.start;
        stop_d  = left_i.stop;
        id_d    = left_i.id;
      end
    end
  end

  // last start at or below the offset, then the end check
  assign match    = le_o && !le_right_i;
  assign in_range = {1'b0, cmd_i.offset} < stop_q;
  assign room     = stop_q - {1'b0, cmd_i.offset};

  always_comb begin
    res_d = '0;
    if (cmd_i.lookup && match && in_range) begin
      res_d.hit  = 1'b1;
      res_d.id   = id_q;
      res_d.fits = {1'b0, cmd_i.length} <= room;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    start_q <= start_d;
    stop_q  <= stop_d;
    id_q    <= id_d;
    if (cmd_i.advance) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule
`default_nettype wire

### test/sorted_address_range_lookup_tb.sv
// testbench: random and directed insert, lookup and clear requests checked against a table predictor
module sorted_address_range_lookup_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 400_000;
  localparam int unsigned RANDOM_REQS = 1150;
  localparam int unsigned MAX_PRINTS  = 50;
  // pipeline is three deep, leave a margin for stray responses
  localparam int unsigned TAIL_CYCLES = 12;

  // how inserted ranges are spread over the address space
  typedef enum int unsigned {
    SPREAD_WIDE,
    SPREAD_DENSE,
    SPREAD_TOP
  } spread_e;

  typedef struct {
    sarl_pkg::kind_e                   kind;
    logic [sarl_pkg::FIELD_W-1:0]      offset;
    logic [sarl_pkg::FIELD_W-1:0]      length;
    logic [sarl_pkg::ID_W-1:0]         seg_id;
    bit                                drain;   // hold off until every response is back
  } request_t;

  typedef struct packed {
    logic                      hit;
    logic [sarl_pkg::ID_W-1:0] found_id;
    logic                      fits;
    logic                      status;
  } answer_t;

  logic clk_i;
  logic rst_ni;

  sarl_req_if req_ch ();
  sarl_rsp_if rsp_ch ();

  sorted_address_range_lookup uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req    (req_ch),
    .rsp    (rsp_ch)
  );

  // stimulus and scoreboard state
  request_t    request_q[$];
  answer_t     answer_q[$];
  int unsigned in_flight;
  int unsigned err_cnt;
  int unsigned req_cnt;
  logic [31:0] cycle_cnt;
  int unsigned send_gap;
  int unsigned stall_left;
  request_t    next_req;
  answer_t     got_answer;
  answer_t     want_answer;

  // predictor copy of the range table, kept sorted by start
  logic [sarl_pkg::ADDR_W-1:0] tbl_start [sarl_pkg::MAX_RANGES];
  logic [sarl_pkg::ADDR_W:0]   tbl_stop  [sarl_pkg::MAX_RANGES];
  logic [sarl_pkg::ID_W-1:0]   tbl_id    [sarl_pkg::MAX_RANGES];
  int unsigned                 tbl_count;

  // ranges inserted in the current episode, used to aim lookups
  logic [sarl_pkg::ADDR_W-1:0] near_start[$];
  logic [sarl_pkg::ADDR_W-1:0] near_len[$];

  // the stretch in which bits 9:8 of the cycle counter are both set runs without gaps on either side
  wire quiet_phase = (cycle_cnt[9:8] == 2'b11);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string msg);
    if (err_cnt < MAX_PRINTS) begin
      $display("%0t ns: mismatch: %s", $time, msg);
    end
    err_cnt++;
  endtask

  task automatic check_field(input string name, input int unsigned got, input int unsigned want);
    if (got != want) begin
      report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    end
  endtask

  // table behavior for one accepted request; updates the predictor copy
  function automatic answer_t table_answer(input sarl_pkg::kind_e kind,
                                           input logic [sarl_pkg::FIELD_W-1:0] offset,
                                           input logic [sarl_pkg::FIELD_W-1:0] length,
                                           input logic [sarl_pkg::ID_W-1:0] seg_id);
    answer_t                     a;
    logic [sarl_pkg::ADDR_W-1:0] addr;
    logic [sarl_pkg::ADDR_W-1:0] size;
    int unsigned                 pos;
    a    = '0;
    addr = offset[sarl_pkg::ADDR_W-1:0];
    size = length[sarl_pkg::ADDR_W-1:0];
    case (kind)
      sarl_pkg::KIND_INSERT: begin
        if (tbl_count >= sarl_pkg::MAX_RANGES) begin
          // table full, request dropped
          a.status = 1'b1;
        end else begin
          // new range goes ahead of any range with an equal start
          pos = 0;
          while (pos < tbl_count && tbl_start[pos] < addr) pos++;
          for (int unsigned i = tbl_count; i > pos; i--) begin
            tbl_start[i] = tbl_start[i-1];
            tbl_stop[i]  = tbl_stop[i-1];
            tbl_id[i]    = tbl_id[i-1];
          end
          tbl_start[pos] = addr;
          tbl_stop[pos]  = {1'b0, addr} + {1'b0, size};
          tbl_id[pos]    = seg_id;
          tbl_count++;
        end
      end
      sarl_pkg::KIND_LOOKUP: begin
        // last range whose start is at or below the offset
        pos = 0;
        while (pos < tbl_count && tbl_start[pos] <= addr) pos++;
        if (pos > 0 && {1'b0, addr} < tbl_stop[pos-1]) begin
          a.hit      = 1'b1;
          a.found_id = tbl_id[pos-1];
          a.fits     = ({1'b0, size} <= tbl_stop[pos-1] - {1'b0, addr});
        end
      end
      sarl_pkg::KIND_CLEAR: begin
        tbl_count = 0;
      end
      default: begin
      end
    endcase
    return a;
  endfunction

  // gap length: mostly none, some short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  task automatic add_request(input sarl_pkg::kind_e kind,
                             input logic [sarl_pkg::FIELD_W-1:0] offset,
                             input logic [sarl_pkg::FIELD_W-1:0] length,
                             input logic [sarl_pkg::ID_W-1:0] seg_id,
                             input bit drain);
    request_t r;
    r.kind   = kind;
    r.offset = offset;
    r.length = length;
    r.seg_id = seg_id;
    r.drain  = drain;
    request_q = {request_q, r};
    if (kind != sarl_pkg::KIND_NOP) req_cnt++;
  endtask

  task automatic add_range(input spread_e spread, input logic [sarl_pkg::ADDR_W-1:0] base);
    logic [sarl_pkg::ADDR_W-1:0] s;
    logic [sarl_pkg::ADDR_W-1:0] l;
    int unsigned                 r;
    r = $urandom_range(0, 9);
    case (spread)
      SPREAD_DENSE: begin
        // small cluster, many equal starts and overlaps
        s = base + 16 * $urandom_range(0, 15);
        l = $urandom_range(0, 64);
      end
      SPREAD_TOP: begin
        // near the top of the address space, ends may pass 2^ADDR_W
        s = '1 - $urandom_range(0, 4095);
        l = (r < 5) ? $urandom : $urandom_range(0, 8192);
      end
      default: begin
        s = $urandom;
        l = (r < 7) ? $urandom_range(0, 4095) : ((r < 9) ? $urandom : '0);
      end
    endcase
    near_start = {near_start, s};
    near_len   = {near_len, l};
    add_request(sarl_pkg::KIND_INSERT, s, l, $urandom_range(0, 65535), 1'b0);
  endtask

  // lookup aimed at the edges of a range from this episode
  task automatic add_lookup();
    int unsigned                 k;
    logic [sarl_pkg::ADDR_W-1:0] s;
    logic [sarl_pkg::ADDR_W:0]   stop;
    logic [sarl_pkg::ADDR_W-1:0] addr;
    logic [sarl_pkg::ADDR_W:0]   room;
    logic [sarl_pkg::ADDR_W-1:0] size;
    if (near_start.size() == 0) begin
      add_request(sarl_pkg::KIND_LOOKUP, $urandom, $urandom_range(0, 255),
                  $urandom_range(0, 65535), 1'b0);
      return;
    end
    k    = $urandom_range(0, near_start.size() - 1);
    s    = near_start[k];
    stop = {1'b0, s} + {1'b0, near_len[k]};
    case ($urandom_range(0, 5))
      0: addr = s;
      1: addr = (near_len[k] == 0) ? s : s + ($urandom % near_len[k]);
      2: addr = stop[sarl_pkg::ADDR_W-1:0] - 1'b1;
      3: addr = stop[sarl_pkg::ADDR_W-1:0];
      4: addr = s - 1'b1;
      default: addr = $urandom;
    endcase
    room = stop - {1'b0, addr};
    case ($urandom_range(0, 5))
      0: size = room[sarl_pkg::ADDR_W-1:0];
      1: size = room[sarl_pkg::ADDR_W-1:0] + 1'b1;
      2: size = room[sarl_pkg::ADDR_W-1:0] - 1'b1;
      3: size = '0;
      4: size = $urandom;
      default: size = $urandom_range(1, 32);
    endcase
    add_request(sarl_pkg::KIND_LOOKUP, addr, size, $urandom_range(0, 65535), 1'b0);
  endtask

  // unaimed traffic, including the unused kind
  task automatic add_noise();
    sarl_pkg::kind_e k;
    k = sarl_pkg::kind_e'($urandom_range(0, 3));
    if (k == sarl_pkg::KIND_CLEAR) k = sarl_pkg::KIND_NOP;
    add_request(k, $urandom, $urandom, $urandom_range(0, 65535), 1'b0);
  endtask

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_ch.valid      <= 1'b0;
      req_ch.kind       <= sarl_pkg::KIND_NOP;
      req_ch.offset     <= '0;
      req_ch.length     <= '0;
      req_ch.segment_id <= '0;
      send_gap          <= 0;
    end else if (!req_ch.valid || req_ch.ready) begin
      if (send_gap != 0) begin
        req_ch.valid <= 1'b0;
        send_gap     <= send_gap - 1;
      end else if (request_q.size() != 0 &&
                   (!request_q[0].drain || (!req_ch.valid && in_flight == 0))) begin
        next_req          = request_q.pop_front();
        req_ch.valid      <= 1'b1;
        req_ch.kind       <= next_req.kind;
        req_ch.offset     <= next_req.offset;
        req_ch.length     <= next_req.length;
        req_ch.segment_id <= next_req.seg_id;
        send_gap          <= quiet_phase ? 0 : pick_gap();
      end else begin
        // nothing to send, or waiting for the pipeline to empty
        req_ch.valid <= 1'b0;
      end
    end
  end

  // response back-pressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_ch.ready <= 1'b0;
      stall_left   <= 0;
    end else if (stall_left != 0) begin
      rsp_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else begin
      int unsigned g;
      g = quiet_phase ? 0 : pick_gap();
      rsp_ch.ready <= (g == 0);
      stall_left   <= (g == 0) ? 0 : g - 1;
    end
  end

  // monitor: check responses first, then predict for the request taken at this edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_flight <= 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (answer_q.size() == 0) begin
          report_mismatch("response with no request outstanding");
        end else begin
          want_answer         = answer_q.pop_front();
          got_answer.hit      = rsp_ch.hit;
          got_answer.found_id = rsp_ch.found_id;
          got_answer.fits     = rsp_ch.fits;
          got_answer.status   = rsp_ch.status;
          check_field("hit", got_answer.hit, want_answer.hit);
          check_field("found_id", got_answer.found_id, want_answer.found_id);
          check_field("fits", got_answer.fits, want_answer.fits);
          check_field("status", got_answer.status, want_answer.status);
        end
      end
      if (req_ch.valid && req_ch.ready) begin
        answer_q = {answer_q, table_answer(sarl_pkg::kind_e'(req_ch.kind), req_ch.offset,
                                           req_ch.length, req_ch.segment_id)};
      end
      in_flight <= in_flight + (req_ch.valid && req_ch.ready) - (rsp_ch.valid && rsp_ch.ready);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("sorted_address_range_lookup_tb NOT OK");
      $finish;
    end
  end

  initial begin
    int unsigned episode;
    int unsigned n_ranges;
    bit          fill;
    spread_e     spread;
    logic [31:0] base;

    cycle_cnt = '0;
    tbl_count = 0;
    err_cnt   = 0;
    req_cnt   = 0;
    rst_ni    = 1'b0;

    // directed: empty table, equal starts, zero length, range ending past 2^32
    add_request(sarl_pkg::KIND_LOOKUP, 32'h0000_0000, 32'h0000_0001, 16'h0000, 1'b0);
    add_request(sarl_pkg::KIND_INSERT, 32'h0000_1000, 32'h0000_0100, 16'hAAAA, 1'b0);
    add_request(sarl_pkg::KIND_INSERT, 32'h0000_1000, 32'h0000_0010, 16'h5555, 1'b0);
    add_request(sarl_pkg::KIND_INSERT, 32'h0000_0000, 32'h0000_0000, 16'h0001, 1'b0);
    add_request(sarl_pkg::KIND_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b0);
    add_request(sarl_pkg::KIND_INSERT, 32'h8000_0000, 32'h0000_0010, 16'h1234, 1'b0);
    add_request(sarl_pkg::KIND_LOOKUP, 32'h0000_0FFF, 32'h0000_0001, 16'h0000, 1'b0);
    add_request(sarl_pkg::KIND_LOOKUP, 32'h0000_0000, 32'h0000_0000, 16'h0000, 1'b0);
    add_request(sarl_pkg::KIND_LOOKUP, 32'h0000_1000, 32'h0000_0100, 16'h0000, 1'b0);
    add_request(sarl_pkg::KIND_LOOKUP, 32'h0000_1000, 32'h0000_0101, 16'h0000, 1'b0);
    add_request(sarl_pkg::KIND_LOOKUP, 32'h0000_10FF, 32'h0000_0001, 16'h0000, 1'b0);
    add_request(sarl_pkg::KIND_LOOKUP, 32'h0000_1100, 32'h0000_0001, 16'h0000, 1'b0);
    add_request(sarl_pkg::KIND_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b0);
    add_request(sarl_pkg::KIND_LOOKUP, 32'h8000_000F, 32'h0000_0000, 16'h0000, 1'b0);
    add_request(sarl_pkg::KIND_LOOKUP, 32'h8000_0010, 32'h0000_0001, 16'h0000, 1'b0);
    add_request(sarl_pkg::KIND_NOP,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b0);
    add_request(sarl_pkg::KIND_CLEAR,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b0);
    add_request(sarl_pkg::KIND_LOOKUP, 32'h0000_1000, 32'h0000_0001, 16'h0000, 1'b0);

    // random episodes: clear, build a table with lookups in between, then probe it;
    // some episodes run past a full table so inserts get dropped
    episode = 0;
    while (req_cnt < RANDOM_REQS) begin
      fill     = (episode == 1) || ($urandom_range(0, 3) == 0);
      spread   = spread_e'($urandom_range(0, 2));
      base     = $urandom;
      n_ranges = fill ? $urandom_range(sarl_pkg::MAX_RANGES, sarl_pkg::MAX_RANGES + 8)
                      : $urandom_range(1, 20);
      // the first clear waits for an empty pipeline, later ones at random
      add_request(sarl_pkg::KIND_CLEAR, $urandom, $urandom, $urandom_range(0, 65535),
                  (episode == 0) || ($urandom_range(0, 4) == 0));
      near_start.delete();
      near_len.delete();
      for (int unsigned i = 0; i < n_ranges; i++) begin
        add_range(spread, base);
        repeat ($urandom_range(0, 2)) add_lookup();
        if ($urandom_range(0, 19) == 0) add_noise();
      end
      repeat ($urandom_range(10, 30)) add_lookup();
      episode++;
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // sampled away from the active edge so the driver and monitor have settled
    do @(negedge clk_i);
    while (request_q.size() != 0 || req_ch.valid || in_flight != 0);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (answer_q.size() != 0) begin
      report_mismatch($sformatf("%0d responses never arrived", answer_q.size()));
    end

    if (err_cnt == 0) begin
      $display("sorted_address_range_lookup_tb OK");
    end else begin
      $display("sorted_address_range_lookup_tb NOT OK");
    end
    $finish;
  end

endmodule

### sim.f
hdl/sarl_pkg.sv
hdl/sarl_if.sv
hdl/sarl_cell.sv
hdl/sorted_address_range_lookup.sv
test/sorted_address_range_lookup_tb.sv
